// ----- hdl/slp_pkg.sv -----
// ----------------------------------------------------------------------------
// slp_pkg
// Shared types, constants and text tables for the SASL EXTERNAL line parser.
// ----------------------------------------------------------------------------
package slp_pkg;

	localparam int MAX_LINE_BYTES = 4096;
	localparam int LB_W           = $clog2(MAX_LINE_BYTES + 2);
	localparam int POS_W          = 13;
	localparam logic [POS_W-1:0] POS_CAP = {POS_W{1'b1}};
	localparam int UID_W          = 32;
	localparam int ACC_W          = 34;
	localparam int ID_MAX_LEN     = 20;

	localparam int NUM_CMDS   = 6;
	localparam int CMD_CHARS  = 17;
	localparam int CMD_SEL_W  = $clog2(NUM_CMDS);
	localparam int CMD_IDX_W  = $clog2(CMD_CHARS);

	localparam int C_AUTH   = 0;
	localparam int C_DATA   = 1;
	localparam int C_BEGIN  = 2;
	localparam int C_CANCEL = 3;
	localparam int C_ERROR  = 4;
	localparam int C_NEGFD  = 5;

	localparam int MECH_LEN  = 8;
	localparam int MECH_IDX_W = $clog2(MECH_LEN);
	localparam logic [POS_W-1:0] ID_OFFSET = POS_W'(MECH_LEN + 1);

	localparam logic [7:0] SPACE = 8'h20;
	localparam logic [7:0] CH_0  = 8'h30;
	localparam logic [7:0] CH_3  = 8'h33;
	localparam logic [7:0] CH_9  = 8'h39;

	typedef logic [8*CMD_CHARS-1:0] cmd_text_t;

	localparam cmd_text_t CMD_TEXT [NUM_CMDS] = '{
		{"AUTH", {13{8'h00}}},
		{"DATA", {13{8'h00}}},
		{"BEGIN", {12{8'h00}}},
		{"CANCEL", {11{8'h00}}},
		{"ERROR", {12{8'h00}}},
		{"NEGOTIATE", "_UNIX_FD"}
	};

	localparam logic [CMD_IDX_W:0] CMD_LEN [NUM_CMDS] = '{
		(CMD_IDX_W+1)'(4), (CMD_IDX_W+1)'(4), (CMD_IDX_W+1)'(5),
		(CMD_IDX_W+1)'(6), (CMD_IDX_W+1)'(5), (CMD_IDX_W+1)'(17)
	};

	localparam logic [8*MECH_LEN-1:0] MECH_TEXT = "EXTERNAL";

	typedef enum logic [1:0] {
		PH_INIT      = 2'd0,
		PH_CHALLENGE = 2'd1,
		PH_AUTHED    = 2'd2
	} session_phase_t;

	typedef enum logic [1:0] {
		FP_COMMAND = 2'd0,
		FP_SKIP    = 2'd1,
		FP_ARG     = 2'd2
	} field_phase_t;

	typedef enum logic [1:0] {
		MP_MATCH = 2'd0,
		MP_SEP   = 2'd1,
		MP_IDENT = 2'd2,
		MP_BAD   = 2'd3
	} mech_phase_t;

	typedef enum logic [2:0] {
		RK_NONE     = 3'd0,
		RK_REJECTED = 3'd1,
		RK_OK       = 3'd2,
		RK_DATA     = 3'd3,
		RK_ERROR    = 3'd4,
		RK_AGREE    = 3'd5
	} reply_kind_t;

	typedef enum logic [1:0] {
		OC_CONT  = 2'd0,
		OC_BEGIN = 2'd1,
		OC_FAIL  = 2'd2
	} outcome_t;

	// line state after the current byte, as seen at the line end
	typedef struct packed {
		field_phase_t            fp;
		logic [NUM_CMDS-1:0]     hits;
		logic [POS_W-1:0]        pos;
		logic                    arg_seen;
		mech_phase_t             mech;
		logic                    id_ok;
		logic                    lead_zero;
		logic                    overlong;
	} line_status_t;

	function automatic logic [7:0] cmd_char(input logic [CMD_SEL_W-1:0] c,
		input logic [CMD_IDX_W-1:0] p);
		logic [7:0] ch;
		ch = 8'h00;
		if (int'(c) < NUM_CMDS && int'(p) < CMD_CHARS) begin
			ch = CMD_TEXT[c][8*CMD_CHARS-1-8*int'(p) -: 8];
		end
		return ch;
	endfunction

	function automatic logic [7:0] mech_char(input logic [MECH_IDX_W-1:0] p);
		return MECH_TEXT[8*MECH_LEN-1-8*int'(p) -: 8];
	endfunction

endpackage

// ----- hdl/slp_if.sv -----
// ----------------------------------------------------------------------------
// slp_if
// Valid/ready channels for line bytes and for replies.
// ----------------------------------------------------------------------------
interface slp_item_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       has_char;
	logic       line_end;

	modport source (output valid, char_code, has_char, line_end, input ready);
	modport sink (input valid, char_code, has_char, line_end, output ready);
endinterface

interface slp_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] reply_kind;
	logic [1:0] outcome;

	modport source (output valid, reply_kind, outcome, input ready);
	modport sink (input valid, reply_kind, outcome, output ready);
endinterface

// ----- hdl/slp_line_scan.sv -----
// ----------------------------------------------------------------------------
// slp_line_scan
// Per-byte line state: command match, argument split, mechanism match and
// running identity check against the configured uid.
// ----------------------------------------------------------------------------
module slp_line_scan (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic [7:0]                 char_code,
	input  logic                       has_char,
	input  logic                       line_end,
	input  logic [slp_pkg::UID_W-1:0]  expected_uid,
	output slp_pkg::line_status_t      status
);
	import slp_pkg::*;

	field_phase_t          fp_q, fp_d;
	logic [NUM_CMDS-1:0]   hits_q, hits_d;
	logic [POS_W-1:0]      pos_q, pos_d;
	logic                  arg_seen_q, arg_seen_d;
	mech_phase_t           mech_q, mech_d;
	logic                  id_ok_q, id_ok_d;
	logic                  lead_q, lead_d;
	logic [ACC_W-1:0]      acc_q, acc_d;
	logic [LB_W-1:0]       lb_q, lb_d;

	logic [POS_W-1:0]      pos_inc;
	logic [POS_W-1:0]      id_idx;
	logic                  id_step;
	logic [ACC_W-1:0]      acc_x10;
	logic [NUM_CMDS-1:0]   len_hits;
	logic [NUM_CMDS-1:0]   end_hits;
	logic [NUM_CMDS-1:0]   char_hits;

	assign pos_inc = (pos_q < POS_CAP) ? pos_q + 1'b1 : pos_q;
	assign acc_x10 = {acc_q[ACC_W-4:0], 3'b000} + {acc_q[ACC_W-2:0], 1'b0};

	always_comb begin
		for (int i = 0; i < NUM_CMDS; i++) begin
			len_hits[i]  = (POS_W'(CMD_LEN[i]) == pos_q);
			end_hits[i]  = (POS_W'(CMD_LEN[i]) == pos_d);
			char_hits[i] = (pos_q < POS_W'(CMD_LEN[i])) &&
				(cmd_char(CMD_SEL_W'(i), pos_q[CMD_IDX_W-1:0]) == char_code);
		end
	end

	always_comb begin
		fp_d       = fp_q;
		hits_d     = hits_q;
		pos_d      = pos_q;
		arg_seen_d = arg_seen_q;
		mech_d     = mech_q;
		lb_d       = lb_q;
		id_step    = 1'b0;
		id_idx     = pos_q;
		if (has_char) begin
			if (lb_q <= LB_W'(MAX_LINE_BYTES)) begin
				lb_d = lb_q + 1'b1;
			end
			case (fp_q)
				FP_COMMAND: begin
					if (char_code == SPACE) begin
						hits_d     = hits_q & len_hits;
						arg_seen_d = 1'b1;
						fp_d       = FP_SKIP;
						pos_d      = '0;
					end else begin
						hits_d = hits_q & char_hits;
						pos_d  = pos_inc;
					end
				end
				FP_SKIP, FP_ARG: begin
					if (!(fp_q == FP_SKIP && char_code == SPACE)) begin
						fp_d  = FP_ARG;
						pos_d = pos_inc;
						if (hits_q[C_AUTH]) begin
							case (mech_q)
								MP_MATCH: begin
									if (pos_q > POS_W'(MECH_LEN - 1) ||
										mech_char(pos_q[MECH_IDX_W-1:0]) != char_code) begin
										mech_d = MP_BAD;
									end else if (pos_q == POS_W'(MECH_LEN - 1)) begin
										mech_d = MP_SEP;
									end
								end
								MP_SEP: begin
									mech_d = (char_code == SPACE) ? MP_IDENT : MP_BAD;
								end
								MP_IDENT: begin
									id_step = 1'b1;
									id_idx  = pos_q - ID_OFFSET;
								end
								default: begin
								end
							endcase
						end else if (hits_q[C_DATA]) begin
							id_step = 1'b1;
							id_idx  = pos_q;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// identity text is pairs of '3' and a decimal digit, folded into a value
	always_comb begin
		id_ok_d = id_ok_q;
		lead_d  = lead_q;
		acc_d   = acc_q;
		if (id_step) begin
			if (id_idx >= POS_W'(ID_MAX_LEN)) begin
				id_ok_d = 1'b0;
			end else if (!id_idx[0]) begin
				if (char_code != CH_3) begin
					id_ok_d = 1'b0;
				end
			end else begin
				if (char_code < CH_0 || char_code > CH_9) begin
					id_ok_d = 1'b0;
				end
				acc_d = acc_x10 + ACC_W'(char_code[3:0]);
				if (id_idx == POS_W'(1)) begin
					lead_d = (char_code == CH_0);
				end
			end
		end
	end

	always_comb begin
		status.fp        = fp_d;
		status.hits      = (fp_d == FP_COMMAND) ? (hits_d & end_hits) : hits_d;
		status.pos       = pos_d;
		status.arg_seen  = arg_seen_d;
		status.mech      = mech_d;
		status.id_ok     = id_ok_d && (acc_d == ACC_W'(expected_uid));
		status.lead_zero = lead_d;
		status.overlong  = (lb_d > LB_W'(MAX_LINE_BYTES));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fp_q       <= FP_COMMAND;
			hits_q     <= '1;
			pos_q      <= '0;
			arg_seen_q <= 1'b0;
			mech_q     <= MP_MATCH;
			id_ok_q    <= 1'b1;
			lead_q     <= 1'b0;
			acc_q      <= '0;
			lb_q       <= '0;
		end else if (step) begin
			if (line_end) begin
				fp_q       <= FP_COMMAND;
				hits_q     <= '1;
				pos_q      <= '0;
				arg_seen_q <= 1'b0;
				mech_q     <= MP_MATCH;
				id_ok_q    <= 1'b1;
				lead_q     <= 1'b0;
				acc_q      <= '0;
				lb_q       <= '0;
			end else begin
				fp_q       <= fp_d;
				hits_q     <= hits_d;
				pos_q      <= pos_d;
				arg_seen_q <= arg_seen_d;
				mech_q     <= mech_d;
				id_ok_q    <= id_ok_d;
				lead_q     <= lead_d;
				acc_q      <= acc_d;
				lb_q       <= lb_d;
			end
		end
	end

endmodule

// ----- hdl/slp_decide.sv -----
// ----------------------------------------------------------------------------
// slp_decide
// Session phase machine: judges a finished line and picks reply and outcome.
// ----------------------------------------------------------------------------
module slp_decide (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   commit,
	input  slp_pkg::line_status_t  status,
	output slp_pkg::reply_kind_t   reply_kind,
	output slp_pkg::outcome_t      outcome
);
	import slp_pkg::*;

	session_phase_t    phase_q, phase_d;
	logic              has_arg;
	logic              auth_pass;
	logic              data_pass;
	logic [POS_W-1:0]  auth_len;
	logic [POS_W-1:0]  data_len;

	function automatic logic id_pass(input logic [POS_W-1:0] len, input logic ok,
		input logic lead_zero);
		return (len == '0) ||
			(ok && !len[0] && !(lead_zero && len > POS_W'(2)));
	endfunction

	assign has_arg   = (status.fp == FP_ARG);
	assign auth_len  = status.pos - ID_OFFSET;
	assign data_len  = has_arg ? status.pos : '0;
	assign auth_pass = id_pass(auth_len, status.id_ok, status.lead_zero);
	assign data_pass = id_pass(data_len, status.id_ok, status.lead_zero);

	// outputs
	always_comb begin
		reply_kind = RK_ERROR;
		outcome    = OC_CONT;
		if (!status.overlong) begin
			case (phase_q)
				PH_INIT: begin
					if (status.hits[C_AUTH]) begin
						if (!status.arg_seen || !has_arg || status.mech == MP_MATCH ||
							status.mech == MP_BAD) begin
							reply_kind = RK_REJECTED;
						end else if (status.mech == MP_SEP || status.pos == ID_OFFSET) begin
							reply_kind = RK_DATA;
						end else begin
							reply_kind = auth_pass ? RK_OK : RK_REJECTED;
						end
					end else if (status.hits[C_ERROR]) begin
						reply_kind = RK_REJECTED;
					end else if (status.hits[C_BEGIN] && !has_arg) begin
						reply_kind = RK_NONE;
						outcome    = OC_FAIL;
					end
				end
				PH_CHALLENGE: begin
					if (status.hits[C_DATA]) begin
						reply_kind = data_pass ? RK_OK : RK_REJECTED;
					end else if (status.hits[C_ERROR] || (status.hits[C_CANCEL] && !has_arg)) begin
						reply_kind = RK_REJECTED;
					end else if (status.hits[C_BEGIN] && !has_arg) begin
						reply_kind = RK_NONE;
						outcome    = OC_FAIL;
					end
				end
				default: begin
					if (status.hits[C_NEGFD] && !has_arg) begin
						reply_kind = RK_AGREE;
					end else if (status.hits[C_BEGIN] && !has_arg) begin
						reply_kind = RK_NONE;
						outcome    = OC_BEGIN;
					end else if (status.hits[C_ERROR] ||
						(status.hits[C_CANCEL] && !has_arg)) begin
						reply_kind = RK_REJECTED;
					end
				end
			endcase
		end
	end

	// next state
	always_comb begin
		phase_d = phase_q;
		if (commit) begin
			case (reply_kind)
				RK_REJECTED: phase_d = PH_INIT;
				RK_DATA:     phase_d = PH_CHALLENGE;
				RK_OK:       phase_d = PH_AUTHED;
				RK_AGREE:    phase_d = PH_AUTHED;
				default:     phase_d = phase_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_INIT;
		end else begin
			phase_q <= phase_d;
		end
	end

endmodule

// ----- hdl/sasl_external_server_line_parser.sv -----
// a reply becomes valid once its closing byte has passed the input register and then the result register
// (two register stages from the item channel to the result channel)
// throughput: one byte per cycle while the byte stage does not stall, set by the per-byte line state update
// the byte stage stalls only while a reply waits and the byte closes another line
// reset clears the session to init, the line state, both stages and the uid to zero
// ----------------------------------------------------------------------------
// sasl_external_server_line_parser
// Server side SASL EXTERNAL line parser: byte stream in, reply kind out.
// ----------------------------------------------------------------------------
module sasl_external_server_line_parser (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [slp_pkg::UID_W-1:0]  cfg_wr_data,
	slp_item_if.sink                   item,
	slp_result_if.source               result
);
	import slp_pkg::*;

	logic [UID_W-1:0]  uid_q;
	logic              valid_s1;
	logic [7:0]        char_s1;
	logic              has_s1;
	logic              end_s1;
	logic              step;
	logic              out_valid_q;
	reply_kind_t       reply_q;
	outcome_t          outcome_q;
	line_status_t      status;
	reply_kind_t       reply_kind;
	outcome_t          outcome;

	assign step       = valid_s1 && (!end_s1 || !out_valid_q || result.ready);
	assign item.ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			uid_q <= '0;
		end else if (cfg_wr_en) begin
			uid_q <= cfg_wr_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.valid && item.ready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			char_s1 <= item.char_code;
			has_s1  <= item.has_char;
			end_s1  <= item.line_end;
		end
	end

	slp_line_scan u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.char_code    (char_s1),
		.has_char     (has_s1),
		.line_end     (end_s1),
		.expected_uid (uid_q),
		.status       (status)
	);

	slp_decide u_decide (
		.clk        (clk),
		.arst_n     (arst_n),
		.commit     (step && end_s1),
		.status     (status),
		.reply_kind (reply_kind),
		.outcome    (outcome)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && end_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && end_s1) begin
			reply_q   <= reply_kind;
			outcome_q <= outcome;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.reply_kind = reply_q;
	assign result.outcome    = outcome_q;

`ifndef SYNTHESIS
	a_reply_after_line_end: assert property (@(posedge clk) disable iff (!arst_n)
		step && end_s1 |=> out_valid_q)
		else $error("line end did not produce a reply transaction");

	a_empty_stage_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> item.ready)
		else $error("byte stage empty but not ready");

	a_silent_reply_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && reply_q == RK_NONE |-> outcome_q == OC_BEGIN || outcome_q == OC_FAIL)
		else $error("reply without text must be begin or failure");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result.ready && valid_s1 && end_s1 |-> !step)
		else $error("pending reply overwritten");
`endif

endmodule

// ----- bench/sasl_external_server_line_parser_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sasl_external_server_line_parser_tb
// Feeds SASL command lines byte by byte through the valid/ready item channel
// and checks every reply against a cycle-free model of the server's line
// parser and session state. Covers directed command sequences, uid settings
// at both extremes and random sessions under idle, stall and a long receiver
// hold-off.
// ----------------------------------------------------------------------------
module sasl_external_server_line_parser_tb;
	import slp_pkg::*;

	typedef bit [7:0] byte_q_t[$];

	typedef struct {
		reply_kind_t rk;
		outcome_t    oc;
	} reply_t;

	localparam int POS_LIMIT = int'(POS_CAP);
	localparam int ID_START  = int'(ID_OFFSET);

	logic             clk;
	logic             arst_n;
	logic             cfg_wr_en;
	logic [UID_W-1:0] cfg_wr_data;

	slp_item_if   item_ch ();
	slp_result_if reply_ch ();

	sasl_external_server_line_parser uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.item       (item_ch),
		.result     (reply_ch)
	);

	string cmd_name [NUM_CMDS] = '{"AUTH", "DATA", "BEGIN", "CANCEL", "ERROR",
		{"NEGOTIATE", "_UNIX_FD"}};
	string mech_name = "EXTERNAL";

	// model of the session and line state
	session_phase_t      sess;
	field_phase_t        fphase;
	logic [NUM_CMDS-1:0] hits;
	int                  pos;
	int                  line_bytes;
	bit                  arg_seen;
	bit                  id_ok;
	mech_phase_t         mech;
	bit [7:0]            id_text [ID_MAX_LEN];
	int                  id_len;

	reply_t           expected_replies[$];
	logic [UID_W-1:0] uid_now;
	int               err_count;
	int               sent_items;
	int               src_idle_pct;
	int               stall_pct;
	int               hold_request;
	int               hold_left;

	always #2 clk = ~clk;

	function automatic void set_uid(logic [UID_W-1:0] v);
		int digits [10];
		int n;
		logic [UID_W-1:0] rest;
		n = 0;
		rest = v;
		do begin
			digits[n] = int'(rest % 10);
			rest = rest / 10;
			n++;
		end while (rest != 0 && n < 10);
		for (int i = 0; i < n; i++) begin
			id_text[2*i] = CH_3;
			id_text[2*i+1] = 8'(CH_0 + digits[n-1-i]);
		end
		id_len = 2 * n;
	endfunction

	function automatic void clear_line_state();
		fphase = FP_COMMAND;
		hits = '1;
		pos = 0;
		arg_seen = 1'b0;
		id_ok = 1'b1;
		mech = MP_MATCH;
		line_bytes = 0;
	endfunction

	function automatic void close_command();
		for (int i = 0; i < NUM_CMDS; i++) begin
			if (cmd_name[i].len() != pos) hits[i] = 1'b0;
		end
	endfunction

	function automatic void check_id_char(int idx, bit [7:0] ch);
		if (idx >= id_len || id_text[idx] != ch) id_ok = 1'b0;
	endfunction

	function automatic void parse_byte(bit [7:0] ch);
		if (fphase == FP_COMMAND) begin
			if (ch == SPACE) begin
				close_command();
				arg_seen = 1'b1;
				fphase = FP_SKIP;
				pos = 0;
				return;
			end
			for (int i = 0; i < NUM_CMDS; i++) begin
				if (pos >= cmd_name[i].len() || 8'(cmd_name[i][pos]) != ch) hits[i] = 1'b0;
			end
			if (pos < POS_LIMIT) pos++;
			return;
		end
		if (fphase == FP_SKIP) begin
			if (ch == SPACE) return;
			fphase = FP_ARG;
		end
		if (hits[C_AUTH]) begin
			case (mech)
				MP_MATCH: begin
					if (pos > MECH_LEN - 1 || 8'(mech_name[pos]) != ch) mech = MP_BAD;
					else if (pos == MECH_LEN - 1) mech = MP_SEP;
				end
				MP_SEP: begin
					mech = (ch == SPACE) ? MP_IDENT : MP_BAD;
				end
				MP_IDENT: begin
					check_id_char(pos - ID_START, ch);
				end
				default: begin
				end
			endcase
		end else if (hits[C_DATA]) begin
			check_id_char(pos, ch);
		end
		if (pos < POS_LIMIT) pos++;
	endfunction

	function automatic reply_kind_t judge_identity(int len);
		if (len == 0 || (id_ok && len == id_len)) begin
			sess = PH_AUTHED;
			return RK_OK;
		end
		sess = PH_INIT;
		return RK_REJECTED;
	endfunction

	function automatic reply_t close_line();
		reply_t r;
		bit has_arg;
		has_arg = (fphase == FP_ARG);
		r.rk = RK_ERROR;
		r.oc = OC_CONT;
		if (line_bytes > MAX_LINE_BYTES) return r;
		if (fphase == FP_COMMAND) close_command();
		if (sess == PH_INIT) begin
			if (hits[C_AUTH]) begin
				if (!arg_seen || !has_arg || mech == MP_MATCH || mech == MP_BAD) begin
					r.rk = RK_REJECTED;
				end else if (mech == MP_SEP || pos == ID_START) begin
					sess = PH_CHALLENGE;
					r.rk = RK_DATA;
				end else begin
					r.rk = judge_identity(pos - ID_START);
				end
			end else if (hits[C_ERROR]) begin
				r.rk = RK_REJECTED;
			end else if (hits[C_BEGIN] && !has_arg) begin
				r.rk = RK_NONE;
				r.oc = OC_FAIL;
			end
		end else if (sess == PH_CHALLENGE) begin
			if (hits[C_DATA]) begin
				r.rk = judge_identity(has_arg ? pos : 0);
			end else if (hits[C_ERROR] || (hits[C_CANCEL] && !has_arg)) begin
				sess = PH_INIT;
				r.rk = RK_REJECTED;
			end else if (hits[C_BEGIN] && !has_arg) begin
				r.rk = RK_NONE;
				r.oc = OC_FAIL;
			end
		end else begin
			if (hits[C_NEGFD] && !has_arg) begin
				sess = PH_AUTHED;
				r.rk = RK_AGREE;
			end else if (hits[C_BEGIN] && !has_arg) begin
				r.rk = RK_NONE;
				r.oc = OC_BEGIN;
			end else if (hits[C_ERROR] || (hits[C_CANCEL] && !has_arg)) begin
				sess = PH_INIT;
				r.rk = RK_REJECTED;
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(string what);
		$display("MISMATCH at %0t: %s", $realtime, what);
		err_count++;
	endtask

	// model update on each input transaction, reply check on each output transaction
	always @(posedge clk) begin
		reply_t want;
		if (arst_n) begin
			if (item_ch.valid && item_ch.ready) begin
				if (item_ch.has_char) begin
					if (line_bytes <= MAX_LINE_BYTES) line_bytes++;
					parse_byte(item_ch.char_code);
				end
				if (item_ch.line_end) begin
					expected_replies.push_back(close_line());
					clear_line_state();
				end
			end
			if (reply_ch.valid && reply_ch.ready) begin
				if (expected_replies.size() == 0) begin
					report_mismatch($sformatf("unexpected reply kind %0d outcome %0d",
						reply_ch.reply_kind, reply_ch.outcome));
				end else begin
					want = expected_replies.pop_front();
					if (reply_ch.reply_kind !== want.rk)
						report_mismatch($sformatf("reply_kind %0d, expected %0d",
							reply_ch.reply_kind, want.rk));
					if (reply_ch.outcome !== want.oc)
						report_mismatch($sformatf("outcome %0d, expected %0d",
							reply_ch.outcome, want.oc));
				end
			end
		end
	end

	// reply side: random stalls plus an optional long hold-off
	always @(posedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			reply_ch.ready <= 1'b0;
		end else begin
			reply_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic send_item(bit [7:0] ch, bit has, bit last);
		while ($urandom_range(99) < src_idle_pct) begin
			item_ch.valid <= 1'b0;
			item_ch.char_code <= 8'($urandom);
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.char_code <= ch;
		item_ch.has_char <= has;
		item_ch.line_end <= last;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		if (has || last) sent_items++;
	endtask

	task automatic src_quiet();
		item_ch.valid <= 1'b0;
	endtask

	task automatic send_line(byte_q_t b);
		bit split;
		split = $urandom_range(1);
		if (b.size() == 0) begin
			send_item(8'($urandom), 1'b0, 1'b1);
			return;
		end
		for (int i = 0; i < b.size(); i++) begin
			if ($urandom_range(99) < 4) send_item(8'($urandom), 1'b0, 1'b0);
			send_item(b[i], 1'b1, (i == b.size() - 1) && !split);
		end
		if (split) send_item(8'($urandom), 1'b0, 1'b1);
	endtask

	task automatic wait_drained();
		while (expected_replies.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_uid(logic [UID_W-1:0] v);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		uid_now = v;
		set_uid(v);
		@(posedge clk);
	endtask

	function automatic byte_q_t text(string s);
		byte_q_t q;
		foreach (s[i]) q.push_back(8'(s[i]));
		return q;
	endfunction

	function automatic string uid_hex(logic [UID_W-1:0] v);
		string d;
		string h;
		d = $sformatf("%0d", v);
		h = "";
		foreach (d[i]) h = {h, $sformatf("%02x", d[i])};
		return h;
	endfunction

	function automatic string identity_arg(bit good);
		string s;
		s = uid_hex(uid_now);
		if (good) return s;
		case ($urandom_range(3))
			0: s = uid_hex(uid_now + 1 + $urandom_range(5));
			1: s = s.substr(0, s.len() - 2);
			2: s = {s, "30"};
			default: s = uid_hex($urandom);
		endcase
		return s;
	endfunction

	function automatic string widen(string s);
		string pad;
		pad = "";
		repeat ($urandom_range(1, 4)) pad = {pad, " "};
		foreach (s[i]) begin
			if (s[i] == " ") return {s.substr(0, i), pad, s.substr(i + 1, s.len() - 1)};
		end
		return s;
	endfunction

	task automatic send_form(string s);
		byte_q_t q;
		if ($urandom_range(99) < 25) s = widen(s);
		q = text(s);
		if (q.size() > 0 && $urandom_range(99) < 8) q[$urandom_range(q.size() - 1)] = 8'($urandom);
		send_line(q);
	endtask

	task automatic send_noise();
		byte_q_t q;
		string mechs [4] = '{"ANONYMOUS", "EXTERNA", "EXTERNALX", "EXTERNAL  31"};
		string typos [4] = '{"NEGOTIATE", "BEGINS", "auth external", "CANCELL"};
		case ($urandom_range(11))
			0: send_line(q);
			1: begin
				repeat ($urandom_range(1, 12)) q.push_back(8'($urandom));
				send_line(q);
			end
			2: send_form("AUTH");
			3: send_form({"AUTH ", mechs[$urandom_range(3)]});
			4: send_form("BEGIN x");
			5: send_form("CANCEL");
			6: send_form("CANCEL x");
			7: send_form("ERROR bad");
			8: send_form({"NEGOTIATE", "_UNIX_FD 1"});
			9: send_form({"DATA ", identity_arg(1'b0)});
			10: send_form("DATA");
			default: send_form(typos[$urandom_range(3)]);
		endcase
	endtask

	task automatic run_session();
		if ($urandom_range(1)) begin
			send_form({"AUTH EXTERNAL ", identity_arg($urandom_range(99) < 75)});
		end else begin
			send_form($urandom_range(1) ? "AUTH EXTERNAL" : "AUTH EXTERNAL ");
			case ($urandom_range(3))
				0: send_form("DATA");
				1: send_form("DATA ");
				default: send_form({"DATA ", identity_arg($urandom_range(99) < 75)});
			endcase
		end
		if ($urandom_range(99) < 20) send_noise();
		if ($urandom_range(99) < 60) send_form({"NEGOTIATE", "_UNIX_FD"});
		case ($urandom_range(9))
			0: send_form("CANCEL");
			1: send_form("ERROR going away");
			default: send_form("BEGIN");
		endcase
	endtask

	task automatic run_random(int target);
		int start;
		start = sent_items;
		while (sent_items - start < target) begin
			if ($urandom_range(99) < 70) run_session();
			else send_noise();
		end
		src_quiet();
	endtask

	task automatic test_reset_uid();
		string lines [5] = '{"AUTH EXTERNAL 30", {"NEGOTIATE", "_UNIX_FD"}, "BEGIN",
			"AUTH EXTERNAL 3030", "AUTH EXTERNAL 31"};
		foreach (lines[i]) send_line(text(lines[i]));
		src_quiet();
	endtask

	task automatic test_directed_commands();
		byte_q_t q;
		string lines [22] = '{"", "AUTH", "AUTH ANONYMOUS", "BEGIN", "ERROR some text",
			"AUTH EXTERNAL 31303031", "AUTH EXTERNAL 31303030", {"NEGOTIATE", "_UNIX_FD"},
			{"NEGOTIATE", "_UNIX_FD x"}, "CANCEL", "AUTH EXTERNAL", "DATA 3130",
			"AUTH EXTERNAL ", "BEGIN", "CANCEL now", "DATA", "BEGIN x", "ERROR",
			"AUTH   EXTERNAL", "DATA    31303030", "BEGIN", "AUTHX"};
		write_uid(32'd1000);
		foreach (lines[i]) send_line(text(lines[i]));
		q = '{8'h00, 8'hFF, 8'h41};
		send_line(q);
		send_item(8'hFF, 1'b0, 1'b0);
		send_line(text("auth external"));
		src_quiet();
	endtask

	task automatic test_random_sessions();
		write_uid('1);
		src_idle_pct = 0;
		stall_pct = 0;
		run_random(150);
		write_uid(UID_W'($urandom));
		src_idle_pct = 53;
		stall_pct = 0;
		run_random(150);
		write_uid('0);
		src_idle_pct = 0;
		stall_pct = 53;
		run_random(150);
		write_uid(UID_W'($urandom_range(9999)));
		src_idle_pct = 14;
		stall_pct = 14;
		run_random(150);
	endtask

	task automatic test_reply_backpressure();
		write_uid(32'd1000);
		src_idle_pct = 0;
		stall_pct = 0;
		hold_request = 400;
		run_random(120);
	endtask

	initial begin
		timeout_guard: begin
			#2_000_000;
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		item_ch.valid = 1'b0;
		item_ch.char_code = '0;
		item_ch.has_char = 1'b0;
		item_ch.line_end = 1'b0;
		reply_ch.ready = 1'b0;
		err_count = 0;
		sent_items = 0;
		src_idle_pct = 0;
		stall_pct = 0;
		hold_request = 0;
		hold_left = 0;
		uid_now = '0;
		sess = PH_INIT;
		clear_line_state();
		set_uid('0);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_uid();
		test_directed_commands();
		test_random_sessions();
		test_reply_backpressure();

		wait_drained();
		if (err_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
